/* rtl/password_class_mask_analyzer_unit_defines.svh */
// ----------------------------------------------------------------------------
// Password class mask analyzer assertion macros
// Shared property macros for the checker of the analyzer unit.
// ----------------------------------------------------------------------------
`ifndef PASSWORD_CLASS_MASK_ANALYZER_UNIT_DEFINES_SVH
`define PASSWORD_CLASS_MASK_ANALYZER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PCMA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pcma same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted.
`define PCMA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pcma next-cycle check failed");

`endif

/* rtl/pcma_pkg.sv */
// ----------------------------------------------------------------------------
// Password class mask analyzer package
// Types, codes and helper functions shared by the analyzer modules.
// ----------------------------------------------------------------------------
package pcma_pkg;

  localparam int MAX_LEN_DEFAULT = 255;
  localparam int CNT_W           = 8;
  localparam int CHARSET_W       = 4;
  localparam int CFG_INDEX_W     = 8;
  localparam int CFG_DATA_W      = 8;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_ADVANCED = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT_SIMPLE   = 8'd1;

  // ASCII bounds of the letter and digit ranges.
  localparam logic [7:0] CHAR_ZERO    = 8'h30;
  localparam logic [7:0] CHAR_NINE    = 8'h39;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;

  typedef enum logic [1:0] {
    CLS_DIGIT   = 2'd0,
    CLS_LOWER   = 2'd1,
    CLS_UPPER   = 2'd2,
    CLS_SPECIAL = 2'd3
  } class_t;

  typedef enum logic [CHARSET_W-1:0] {
    CS_NUMERIC              = 4'd0,
    CS_LOWERALPHA           = 4'd1,
    CS_UPPERALPHA           = 4'd2,
    CS_SPECIAL              = 4'd3,
    CS_MIXEDALPHA           = 4'd4,
    CS_LOWERALPHANUM        = 4'd5,
    CS_UPPERALPHANUM        = 4'd6,
    CS_LOWERALPHASPECIAL    = 4'd7,
    CS_UPPERALPHASPECIAL    = 4'd8,
    CS_SPECIALNUM           = 4'd9,
    CS_MIXEDALPHASPECIAL    = 4'd10,
    CS_UPPERALPHASPECIALNUM = 4'd11,
    CS_LOWERALPHASPECIALNUM = 4'd12,
    CS_MIXEDALPHANUM        = 4'd13,
    CS_ALL                  = 4'd14
  } charset_t;

  typedef struct packed {
    logic             valid;
    logic [CNT_W-1:0] pw_length;
    logic [CNT_W-1:0] digits;
    logic [CNT_W-1:0] lowers;
    logic [CNT_W-1:0] uppers;
    logic [CNT_W-1:0] specials;
    logic [CNT_W-1:0] simple_tokens;
    charset_t         charset;
    logic             advanced_over;
    logic             simple_over;
  } summary_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v,
                                               input logic [CNT_W-1:0] cap);
    sat_inc = (v < cap) ? v + CNT_W'(1) : cap;
  endfunction

  // Presence mask: bit 0 digit, bit 1 lower, bit 2 upper, bit 3 special.
  function automatic charset_t charset_of(input logic [3:0] mask);
    case (mask)
      4'b0001: charset_of = CS_NUMERIC;
      4'b0010: charset_of = CS_LOWERALPHA;
      4'b0011: charset_of = CS_LOWERALPHANUM;
      4'b0100: charset_of = CS_UPPERALPHA;
      4'b0101: charset_of = CS_UPPERALPHANUM;
      4'b0110: charset_of = CS_MIXEDALPHA;
      4'b0111: charset_of = CS_MIXEDALPHANUM;
      4'b1000: charset_of = CS_SPECIAL;
      4'b1001: charset_of = CS_SPECIALNUM;
      4'b1010: charset_of = CS_LOWERALPHASPECIAL;
      4'b1011: charset_of = CS_LOWERALPHASPECIALNUM;
      4'b1100: charset_of = CS_UPPERALPHASPECIAL;
      4'b1101: charset_of = CS_UPPERALPHASPECIALNUM;
      4'b1110: charset_of = CS_MIXEDALPHASPECIAL;
      default: charset_of = CS_ALL;
    endcase
  endfunction

endpackage

/* rtl/pcma_classify.sv */
// ----------------------------------------------------------------------------
// Password byte classifier
// Sorts one byte into digit, lower, upper or special.
// ----------------------------------------------------------------------------
module pcma_classify (
  input  logic [7:0]       char_code,
  output pcma_pkg::class_t class_code
);

  always_comb begin
    if (char_code inside {[pcma_pkg::CHAR_ZERO:pcma_pkg::CHAR_NINE]}) begin
      class_code = pcma_pkg::CLS_DIGIT;
    end else if (char_code inside {[pcma_pkg::CHAR_LOWER_A:pcma_pkg::CHAR_LOWER_Z]}) begin
      class_code = pcma_pkg::CLS_LOWER;
    end else if (char_code inside {[pcma_pkg::CHAR_UPPER_A:pcma_pkg::CHAR_UPPER_Z]}) begin
      class_code = pcma_pkg::CLS_UPPER;
    end else begin
      class_code = pcma_pkg::CLS_SPECIAL;
    end
  end

endmodule

/* rtl/pcma_stats.sv */
// ----------------------------------------------------------------------------
// Password statistics accumulator
// Per-class counters, length, run tracking and the end-of-password summary.
// ----------------------------------------------------------------------------
module pcma_stats #(
  parameter int MAX_LEN = pcma_pkg::MAX_LEN_DEFAULT
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       step,
  input  pcma_pkg::class_t           class_code,
  input  logic                       is_last,
  input  logic [pcma_pkg::CNT_W-1:0] limit_advanced,
  input  logic [pcma_pkg::CNT_W-1:0] limit_simple,
  output logic                       run_start,
  output pcma_pkg::summary_t         summary
);

  localparam int CNT_MAX = (1 << pcma_pkg::CNT_W) - 1;
  localparam logic [pcma_pkg::CNT_W-1:0] CNT_CAP =
    pcma_pkg::CNT_W'((MAX_LEN < CNT_MAX) ? MAX_LEN : CNT_MAX);

  logic [pcma_pkg::CNT_W-1:0] char_cnt_r, char_cnt_nxt;
  logic [pcma_pkg::CNT_W-1:0] digit_cnt_r, digit_cnt_nxt;
  logic [pcma_pkg::CNT_W-1:0] lower_cnt_r, lower_cnt_nxt;
  logic [pcma_pkg::CNT_W-1:0] upper_cnt_r, upper_cnt_nxt;
  logic [pcma_pkg::CNT_W-1:0] special_cnt_r, special_cnt_nxt;
  logic [pcma_pkg::CNT_W-1:0] token_cnt_r, token_cnt_nxt;
  pcma_pkg::class_t           prev_class_r;
  logic                       prev_valid_r;
  logic [3:0]                 mask;

  // The first byte of a password always opens a new run.
  assign run_start = !prev_valid_r || (class_code != prev_class_r);

  always_comb begin
    char_cnt_nxt    = pcma_pkg::sat_inc(char_cnt_r, CNT_CAP);
    digit_cnt_nxt   = digit_cnt_r;
    lower_cnt_nxt   = lower_cnt_r;
    upper_cnt_nxt   = upper_cnt_r;
    special_cnt_nxt = special_cnt_r;
    case (class_code)
      pcma_pkg::CLS_DIGIT: digit_cnt_nxt = pcma_pkg::sat_inc(digit_cnt_r, CNT_CAP);
      pcma_pkg::CLS_LOWER: lower_cnt_nxt = pcma_pkg::sat_inc(lower_cnt_r, CNT_CAP);
      pcma_pkg::CLS_UPPER: upper_cnt_nxt = pcma_pkg::sat_inc(upper_cnt_r, CNT_CAP);
      default:             special_cnt_nxt = pcma_pkg::sat_inc(special_cnt_r, CNT_CAP);
    endcase
    token_cnt_nxt = run_start ? pcma_pkg::sat_inc(token_cnt_r, CNT_CAP) : token_cnt_r;
  end

  assign mask = {special_cnt_nxt != '0, upper_cnt_nxt != '0,
                 lower_cnt_nxt != '0, digit_cnt_nxt != '0};

  always_comb begin
    summary = '0;
    if (is_last) begin
      summary.valid         = 1'b1;
      summary.pw_length     = char_cnt_nxt;
      summary.digits        = digit_cnt_nxt;
      summary.lowers        = lower_cnt_nxt;
      summary.uppers        = upper_cnt_nxt;
      summary.specials      = special_cnt_nxt;
      summary.simple_tokens = token_cnt_nxt;
      summary.charset       = pcma_pkg::charset_of(mask);
      summary.advanced_over = (limit_advanced != '0) && (char_cnt_nxt > limit_advanced);
      summary.simple_over   = (limit_simple != '0) && (token_cnt_nxt > limit_simple);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      char_cnt_r    <= '0;
      digit_cnt_r   <= '0;
      lower_cnt_r   <= '0;
      upper_cnt_r   <= '0;
      special_cnt_r <= '0;
      token_cnt_r   <= '0;
      prev_valid_r  <= 1'b0;
    end else if (step) begin
      if (is_last) begin
        char_cnt_r    <= '0;
        digit_cnt_r   <= '0;
        lower_cnt_r   <= '0;
        upper_cnt_r   <= '0;
        special_cnt_r <= '0;
        token_cnt_r   <= '0;
        prev_valid_r  <= 1'b0;
      end else begin
        char_cnt_r    <= char_cnt_nxt;
        digit_cnt_r   <= digit_cnt_nxt;
        lower_cnt_r   <= lower_cnt_nxt;
        upper_cnt_r   <= upper_cnt_nxt;
        special_cnt_r <= special_cnt_nxt;
        token_cnt_r   <= token_cnt_nxt;
        prev_valid_r  <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      prev_class_r <= class_code;
    end
  end

endmodule

/* rtl/password_class_mask_analyzer_unit.sv */
// Path: an accepted beat is held in the input register, then in the result register.
// Throughput: one byte per cycle if not stalled; the counter update loop sets it.
// Both registers advance together whenever the result register is empty or
// being taken, so a stalled output holds at most one beat in each.
// Reset (rst_n low, synchronous) clears both limits, all counters and the beat
// and run valid flags; the block accepts beats in the first cycle after reset.
// ----------------------------------------------------------------------------
// Password class mask analyzer
// Classifies password bytes and reports per-password class statistics.
// ----------------------------------------------------------------------------
module password_class_mask_analyzer_unit #(
  parameter int MAX_LEN = pcma_pkg::MAX_LEN_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [pcma_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pcma_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [7:0]                       in_char_code,
  input  logic                             in_is_last,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       out_class_code,
  output logic                             out_run_start,
  output logic                             out_summary_valid,
  output logic [pcma_pkg::CNT_W-1:0]       out_pw_length,
  output logic [pcma_pkg::CNT_W-1:0]       out_digits,
  output logic [pcma_pkg::CNT_W-1:0]       out_lowers,
  output logic [pcma_pkg::CNT_W-1:0]       out_uppers,
  output logic [pcma_pkg::CNT_W-1:0]       out_specials,
  output logic [pcma_pkg::CNT_W-1:0]       out_simple_tokens,
  output logic [pcma_pkg::CHARSET_W-1:0]   out_charset,
  output logic                             out_advanced_over,
  output logic                             out_simple_over
);

  logic [pcma_pkg::CNT_W-1:0] limit_advanced_r;
  logic [pcma_pkg::CNT_W-1:0] limit_simple_r;

  logic               in_valid_r;
  logic [7:0]         in_char_r;
  logic               in_last_r;
  logic               advance;
  logic               step;

  pcma_pkg::class_t   cls;
  logic               run_start;
  pcma_pkg::summary_t summary;

  logic               out_valid_r;
  pcma_pkg::class_t   out_class_r;
  logic               out_run_start_r;
  pcma_pkg::summary_t out_summary_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_advanced_r <= '0;
      limit_simple_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pcma_pkg::REG_LIMIT_ADVANCED: limit_advanced_r <= cfg_data;
        pcma_pkg::REG_LIMIT_SIMPLE:   limit_simple_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Both stages move as one when the result register can take a new beat.
  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign step     = advance && in_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (advance) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      in_char_r <= in_char_code;
      in_last_r <= in_is_last;
    end
  end

  pcma_classify u_classify (
    .char_code  (in_char_r),
    .class_code (cls)
  );

  pcma_stats #(
    .MAX_LEN (MAX_LEN)
  ) u_stats (
    .clk            (clk),
    .rst_n          (rst_n),
    .step           (step),
    .class_code     (cls),
    .is_last        (in_last_r),
    .limit_advanced (limit_advanced_r),
    .limit_simple   (limit_simple_r),
    .run_start      (run_start),
    .summary        (summary)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_class_r     <= cls;
      out_run_start_r <= run_start;
      out_summary_r   <= summary;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_class_code    = out_class_r;
  assign out_run_start     = out_run_start_r;
  assign out_summary_valid = out_summary_r.valid;
  assign out_pw_length     = out_summary_r.pw_length;
  assign out_digits        = out_summary_r.digits;
  assign out_lowers        = out_summary_r.lowers;
  assign out_uppers        = out_summary_r.uppers;
  assign out_specials      = out_summary_r.specials;
  assign out_simple_tokens = out_summary_r.simple_tokens;
  assign out_charset       = out_summary_r.charset;
  assign out_advanced_over = out_summary_r.advanced_over;
  assign out_simple_over   = out_summary_r.simple_over;

endmodule

/* rtl/pcma_checker.sv */
// ----------------------------------------------------------------------------
// Password class mask analyzer checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "password_class_mask_analyzer_unit_defines.svh"

module pcma_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [1:0]                     out_class_code,
  input logic                           out_summary_valid,
  input logic [pcma_pkg::CNT_W-1:0]     out_pw_length,
  input logic [pcma_pkg::CNT_W-1:0]     out_digits,
  input logic [pcma_pkg::CNT_W-1:0]     out_simple_tokens,
  input logic [pcma_pkg::CHARSET_W-1:0] out_charset,
  input logic                           out_advanced_over,
  input logic                           out_simple_over
);

  logic       stalled;
  logic [2:0] held;
  logic       mid_beat;
  logic       mid_zero;
  logic       end_beat;
  logic       tokens_ok;
  logic       numeric_end;
  logic       numeric_ok;

  assign stalled     = out_valid && !out_ready;
  assign held        = {out_class_code, out_summary_valid};
  assign mid_beat    = out_valid && !out_summary_valid;
  assign mid_zero    = out_pw_length == '0 && out_digits == '0 && out_simple_tokens == '0 &&
                       out_charset == '0 && !out_advanced_over && !out_simple_over;
  assign end_beat    = out_valid && out_summary_valid;
  assign tokens_ok   = out_pw_length != '0 && out_simple_tokens != '0 &&
                       out_simple_tokens <= out_pw_length;
  assign numeric_end = end_beat && out_charset == pcma_pkg::CS_NUMERIC;
  assign numeric_ok  = out_digits == out_pw_length && out_class_code == pcma_pkg::CLS_DIGIT;

  // A stalled result beat keeps its class and summary flag.
  `PCMA_ASSERT_NEXT(a_out_hold, clk, rst_n, stalled, out_valid && $stable(held))

  // Mid-password beats carry zero length, digits, tokens, charset and over flags.
  `PCMA_ASSERT_SAME(a_mid_zero, clk, rst_n, mid_beat, mid_zero)

  // A finished password has at least one byte and no more runs than bytes.
  `PCMA_ASSERT_SAME(a_tokens_bound, clk, rst_n, end_beat, tokens_ok)

  // A digit-only charset means every byte was a digit.
  `PCMA_ASSERT_SAME(a_numeric_only, clk, rst_n, numeric_end, numeric_ok)

endmodule

bind password_class_mask_analyzer_unit pcma_checker u_pcma_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_class_code    (out_class_code),
  .out_summary_valid (out_summary_valid),
  .out_pw_length     (out_pw_length),
  .out_digits        (out_digits),
  .out_simple_tokens (out_simple_tokens),
  .out_charset       (out_charset),
  .out_advanced_over (out_advanced_over),
  .out_simple_over   (out_simple_over)
);

/* tb/sv/password_class_mask_analyzer_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Password class mask analyzer testbench
// Streams passwords byte by byte through the analyzer and checks every result
// beat against a cycle-free predictor. A short table of directed bytes runs
// first. Random passwords follow, under several limit settings and idle
// patterns on both sides.
// ----------------------------------------------------------------------------
module password_class_mask_analyzer_unit_tb;
  import pcma_pkg::*;

  localparam logic [2:0]             CLASS_NONE = 3'd4;
  localparam logic [CNT_W-1:0]       COUNT_CAP  = 8'd255;
  localparam logic [CFG_INDEX_W-1:0] REG_COUNT  = 8'd2;

  typedef struct packed {
    class_t           class_code;
    logic             run_start;
    logic             summary_valid;
    logic [CNT_W-1:0] pw_length;
    logic [CNT_W-1:0] digits;
    logic [CNT_W-1:0] lowers;
    logic [CNT_W-1:0] uppers;
    logic [CNT_W-1:0] specials;
    logic [CNT_W-1:0] simple_tokens;
    charset_t         charset;
    logic             advanced_over;
    logic             simple_over;
  } analysis_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       typed;
    analysis_t  want;
  } directed_row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_valid;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic in_valid;
  logic in_ready;
  logic [7:0] in_char_code;
  logic in_is_last;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_class_code;
  logic out_run_start;
  logic out_summary_valid;
  logic [CNT_W-1:0] out_pw_length;
  logic [CNT_W-1:0] out_digits;
  logic [CNT_W-1:0] out_lowers;
  logic [CNT_W-1:0] out_uppers;
  logic [CNT_W-1:0] out_specials;
  logic [CNT_W-1:0] out_simple_tokens;
  logic [CHARSET_W-1:0] out_charset;
  logic out_advanced_over;
  logic out_simple_over;

  password_class_mask_analyzer_unit dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_char_code      (in_char_code),
    .in_is_last        (in_is_last),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_class_code    (out_class_code),
    .out_run_start     (out_run_start),
    .out_summary_valid (out_summary_valid),
    .out_pw_length     (out_pw_length),
    .out_digits        (out_digits),
    .out_lowers        (out_lowers),
    .out_uppers        (out_uppers),
    .out_specials      (out_specials),
    .out_simple_tokens (out_simple_tokens),
    .out_charset       (out_charset),
    .out_advanced_over (out_advanced_over),
    .out_simple_over   (out_simple_over)
  );

  always #6 clk = ~clk;

  // Predictor state: one password in progress plus the two limits.
  logic [7:0]       adv_limit;
  logic [7:0]       simple_limit;
  logic [CNT_W-1:0] digit_cnt, lower_cnt, upper_cnt, special_cnt, length_cnt, token_cnt;
  logic [2:0]       last_class;

  // Charset category by presence mask: bit 0 digit, 1 lower, 2 upper, 3 special.
  charset_t charset_by_presence [16] = '{
    CS_ALL, CS_NUMERIC, CS_LOWERALPHA, CS_LOWERALPHANUM,
    CS_UPPERALPHA, CS_UPPERALPHANUM, CS_MIXEDALPHA, CS_MIXEDALPHANUM,
    CS_SPECIAL, CS_SPECIALNUM, CS_LOWERALPHASPECIAL, CS_LOWERALPHASPECIALNUM,
    CS_UPPERALPHASPECIAL, CS_UPPERALPHASPECIALNUM, CS_MIXEDALPHASPECIAL, CS_ALL
  };

  analysis_t pending_results[$];
  directed_row_t directed_rows[25];
  int mismatches = 0;
  int taken_count = 0;
  int bytes_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;

  function automatic class_t class_of(input logic [7:0] c);
    if (c >= CHAR_ZERO && c <= CHAR_NINE) return CLS_DIGIT;
    if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) return CLS_LOWER;
    if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) return CLS_UPPER;
    return CLS_SPECIAL;
  endfunction

  function automatic logic [CNT_W-1:0] bump(input logic [CNT_W-1:0] v);
    return (v < COUNT_CAP) ? v + 8'd1 : COUNT_CAP;
  endfunction

  function automatic analysis_t typed_result(input class_t c, input logic run,
                                             input int len, input int d,
                                             input int l, input int u,
                                             input int s, input int tok,
                                             input charset_t cs);
    analysis_t r;
    r = '0;
    r.class_code    = c;
    r.run_start     = run;
    r.summary_valid = (len != 0);
    r.pw_length     = 8'(len);
    r.digits        = 8'(d);
    r.lowers        = 8'(l);
    r.uppers        = 8'(u);
    r.specials      = 8'(s);
    r.simple_tokens = 8'(tok);
    r.charset       = cs;
    return r;
  endfunction

  task automatic clear_password();
    digit_cnt   = '0;
    lower_cnt   = '0;
    upper_cnt   = '0;
    special_cnt = '0;
    length_cnt  = '0;
    token_cnt   = '0;
    last_class  = CLASS_NONE;
  endtask

  task automatic analyze_byte(input logic [7:0] ch, input logic last, output analysis_t r);
    class_t c;
    logic [3:0] present;
    c = class_of(ch);
    r = '0;
    r.class_code = c;
    r.run_start  = ({1'b0, c} != last_class);
    length_cnt = bump(length_cnt);
    case (c)
      CLS_DIGIT: digit_cnt = bump(digit_cnt);
      CLS_LOWER: lower_cnt = bump(lower_cnt);
      CLS_UPPER: upper_cnt = bump(upper_cnt);
      default:   special_cnt = bump(special_cnt);
    endcase
    if (r.run_start) token_cnt = bump(token_cnt);
    last_class = {1'b0, c};
    if (last) begin
      present = {special_cnt != 0, upper_cnt != 0, lower_cnt != 0, digit_cnt != 0};
      r.summary_valid = 1'b1;
      r.pw_length     = length_cnt;
      r.digits        = digit_cnt;
      r.lowers        = lower_cnt;
      r.uppers        = upper_cnt;
      r.specials      = special_cnt;
      r.simple_tokens = token_cnt;
      r.charset       = charset_by_presence[present];
      r.advanced_over = (adv_limit != 0) && (length_cnt > adv_limit);
      r.simple_over   = (simple_limit != 0) && (token_cnt > simple_limit);
      clear_password();
    end
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("%0t: result %0d, %s: got %0d, expected %0d", $realtime, taken_count, what,
             got, want);
    mismatches++;
  endtask

  task automatic check_result();
    analysis_t want;
    if (pending_results.size() == 0) begin
      report_mismatch("beat with no result pending", 1, 0);
    end else begin
      want = pending_results.pop_front();
      if (out_class_code !== want.class_code)
        report_mismatch("class_code", out_class_code, want.class_code);
      if (out_run_start !== want.run_start)
        report_mismatch("run_start", out_run_start, want.run_start);
      if (out_summary_valid !== want.summary_valid)
        report_mismatch("summary_valid", out_summary_valid, want.summary_valid);
      if (out_pw_length !== want.pw_length)
        report_mismatch("pw_length", out_pw_length, want.pw_length);
      if (out_digits !== want.digits)
        report_mismatch("digits", out_digits, want.digits);
      if (out_lowers !== want.lowers)
        report_mismatch("lowers", out_lowers, want.lowers);
      if (out_uppers !== want.uppers)
        report_mismatch("uppers", out_uppers, want.uppers);
      if (out_specials !== want.specials)
        report_mismatch("specials", out_specials, want.specials);
      if (out_simple_tokens !== want.simple_tokens)
        report_mismatch("simple_tokens", out_simple_tokens, want.simple_tokens);
      if (out_charset !== want.charset)
        report_mismatch("charset", out_charset, want.charset);
      if (out_advanced_over !== want.advanced_over)
        report_mismatch("advanced_over", out_advanced_over, want.advanced_over);
      if (out_simple_over !== want.simple_over)
        report_mismatch("simple_over", out_simple_over, want.simple_over);
    end
  endtask

  // Result side: checks each taken beat and decides out_ready for the next edge.
  // Once the stream runs with no idling, it holds off for a long stretch so the
  // block fills up and pushes back on the sender.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result();
      taken_count++;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else if (!hold_done && rst_n && recv_idle_pct == 0 && taken_count >= 1100) begin
      hold_done = 1'b1;
      hold_left = 64;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_byte(input logic [7:0] ch, input logic last, input logic typed,
                           input analysis_t typed_want);
    analysis_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_char_code <= ch;
    in_is_last   <= last;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    analyze_byte(ch, last, r);
    pending_results.push_back(typed ? typed_want : r);
    bytes_sent++;
  endtask

  function automatic logic [7:0] byte_of_class(input class_t c);
    logic [7:0] v;
    case (c)
      CLS_DIGIT: v = CHAR_ZERO + 8'($urandom_range(9));
      CLS_LOWER: v = CHAR_LOWER_A + 8'($urandom_range(25));
      CLS_UPPER: v = CHAR_UPPER_A + 8'($urandom_range(25));
      default: begin
        do v = 8'($urandom_range(255)); while (class_of(v) != CLS_SPECIAL);
      end
    endcase
    return v;
  endfunction

  // A class mask of zero sends raw random bytes. Otherwise the class is drawn
  // from the mask, kept from the byte before with the given chance; a chance of
  // zero forces a new run on every byte when the mask allows it.
  task automatic send_password(input int len, input logic [3:0] mask, input int stay_pct);
    class_t c;
    logic [7:0] ch;
    logic change;
    c = CLS_DIGIT;
    for (int i = 0; i < len; i++) begin
      if (mask == 4'd0) begin
        ch = 8'($urandom_range(255));
      end else begin
        change = (i == 0) || ($urandom_range(99) >= stay_pct);
        if (change) begin
          do c = class_t'($urandom_range(3));
          while (!mask[c] || (stay_pct == 0 && i != 0 && $countones(mask) > 1 &&
                              {1'b0, c} == last_class));
        end
        ch = byte_of_class(c);
      end
      send_byte(ch, i == len - 1, 1'b0, '0);
    end
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_LIMIT_ADVANCED) adv_limit = val;
    else if (idx == REG_LIMIT_SIMPLE) simple_limit = val;
  endtask

  // An index past the register file goes in first; it must change nothing.
  task automatic set_limits(input logic [7:0] adv, input logic [7:0] simp);
    write_reg(REG_COUNT + 8'($urandom_range(253)), 8'($urandom_range(255)));
    write_reg(REG_LIMIT_ADVANCED, adv);
    write_reg(REG_LIMIT_SIMPLE, simp);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin
    int phase_start;
    int len;
    rst_n        <= 1'b0;
    cfg_valid    <= 1'b0;
    cfg_index    <= '0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    in_char_code <= '0;
    in_is_last   <= 1'b0;
    adv_limit    = '0;
    simple_limit = '0;
    clear_password();

    directed_rows = '{
      '{CHAR_ZERO, 1'b1, 1'b1, typed_result(CLS_DIGIT, 1'b1, 1, 1, 0, 0, 0, 1, CS_NUMERIC)},
      '{CHAR_NINE, 1'b1, 1'b1, typed_result(CLS_DIGIT, 1'b1, 1, 1, 0, 0, 0, 1, CS_NUMERIC)},
      '{CHAR_LOWER_A, 1'b1, 1'b1,
        typed_result(CLS_LOWER, 1'b1, 1, 0, 1, 0, 0, 1, CS_LOWERALPHA)},
      '{CHAR_LOWER_Z, 1'b1, 1'b1,
        typed_result(CLS_LOWER, 1'b1, 1, 0, 1, 0, 0, 1, CS_LOWERALPHA)},
      '{CHAR_UPPER_A, 1'b1, 1'b1,
        typed_result(CLS_UPPER, 1'b1, 1, 0, 0, 1, 0, 1, CS_UPPERALPHA)},
      '{CHAR_UPPER_Z, 1'b1, 1'b1,
        typed_result(CLS_UPPER, 1'b1, 1, 0, 0, 1, 0, 1, CS_UPPERALPHA)},
      '{8'h00, 1'b1, 1'b1, typed_result(CLS_SPECIAL, 1'b1, 1, 0, 0, 0, 1, 1, CS_SPECIAL)},
      '{8'hff, 1'b1, 1'b1, typed_result(CLS_SPECIAL, 1'b1, 1, 0, 0, 0, 1, 1, CS_SPECIAL)},
      // Neighbors of each letter and digit range are all special bytes.
      '{8'h2f, 1'b0, 1'b1, typed_result(CLS_SPECIAL, 1'b1, 0, 0, 0, 0, 0, 0, CS_NUMERIC)},
      '{8'h3a, 1'b0, 1'b1, typed_result(CLS_SPECIAL, 1'b0, 0, 0, 0, 0, 0, 0, CS_NUMERIC)},
      '{8'h40, 1'b0, 1'b1, typed_result(CLS_SPECIAL, 1'b0, 0, 0, 0, 0, 0, 0, CS_NUMERIC)},
      '{8'h5b, 1'b0, 1'b1, typed_result(CLS_SPECIAL, 1'b0, 0, 0, 0, 0, 0, 0, CS_NUMERIC)},
      '{8'h60, 1'b0, 1'b1, typed_result(CLS_SPECIAL, 1'b0, 0, 0, 0, 0, 0, 0, CS_NUMERIC)},
      '{8'h7b, 1'b0, 1'b1, typed_result(CLS_SPECIAL, 1'b0, 0, 0, 0, 0, 0, 0, CS_NUMERIC)},
      '{8'h80, 1'b1, 1'b1, typed_result(CLS_SPECIAL, 1'b0, 7, 0, 0, 0, 7, 1, CS_SPECIAL)},
      '{8'h50, 1'b0, 1'b0, '0},
      '{8'h61, 1'b0, 1'b0, '0},
      '{8'h73, 1'b0, 1'b0, '0},
      '{8'h73, 1'b0, 1'b0, '0},
      '{8'h31, 1'b0, 1'b0, '0},
      '{8'h32, 1'b0, 1'b0, '0},
      '{8'h21, 1'b0, 1'b0, '0},
      '{8'h51, 1'b1, 1'b0, '0},
      '{8'h78, 1'b0, 1'b0, '0},
      '{8'h37, 1'b1, 1'b0, '0}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bytes run with the limits at their reset values.
    foreach (directed_rows[i])
      send_byte(directed_rows[i].ch, directed_rows[i].last, directed_rows[i].typed,
                directed_rows[i].want);

    for (int phase = 0; phase < 6; phase++) begin
      drain_results();
      case (phase)
        0: set_limits(8'd255, 8'd255);
        1: set_limits(8'd1, 8'd1);
        2: set_limits(8'($urandom_range(2, 30)), 8'($urandom_range(2, 12)));
        3: set_limits(8'd0, 8'($urandom_range(1, 12)));
        4: set_limits(8'($urandom_range(1, 20)), 8'd0);
        default: set_limits(8'($urandom_range(255)), 8'($urandom_range(255)));
      endcase
      send_idle_pct = (phase < 2) ? 32 : (phase < 4) ? 86 : 0;
      recv_idle_pct = (phase < 2) ? 86 : (phase < 4) ? 32 : 0;
      phase_start = bytes_sent;
      // Long passwords drive length, class and token counters into saturation.
      if (phase == 0) begin
        send_password(300, 4'b1111, 0);
        send_password(280, 4'b0001, 100);
      end else if (phase == 1) begin
        send_password(270, 4'b0110, 0);
      end
      while (bytes_sent - phase_start < 170) begin
        len = ($urandom_range(99) < 3) ? $urandom_range(250, 300) : $urandom_range(1, 24);
        if ($urandom_range(7) == 0) send_password(len, 4'd0, 0);
        else send_password(len, 4'($urandom_range(1, 15)), $urandom_range(0, 80));
      end
    end

    drain_results();
    if (pending_results.size() != 0)
      report_mismatch("results never delivered", 0, pending_results.size());
    if (mismatches == 0) begin
      $display("[password_class_mask_analyzer_unit] OK");
    end else begin
      $display("[password_class_mask_analyzer_unit] ERROR");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("[password_class_mask_analyzer_unit] ERROR");
    $finish;
  end

endmodule
